// ===== design/cir_pkg.sv =====
// shared types, constants and helpers of the contact impulse resolver
package cir_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DIV_STEPS = 31;
    localparam logic [30:0] Q_MAX = 31'h7fffffff;
    localparam logic [16:0] RESTITUTION_RESET = 17'd32768;
    localparam logic signed [48:0] SAT_HI = 49'sd2147483647;
    localparam logic signed [48:0] SAT_LO = -49'sd2147483648;

    // one contact as it arrives on the input stream
    typedef struct packed {
        logic signed [31:0] penetration;
        logic signed [17:0] normal_y;
        logic signed [17:0] normal_x;
        logic [30:0]        inv_mass_b;
        logic [30:0]        inv_mass_a;
        logic signed [31:0] rel_acc_y;
        logic signed [31:0] rel_acc_x;
        logic signed [31:0] vel_b_y;
        logic signed [31:0] vel_b_x;
        logic signed [31:0] vel_a_y;
        logic signed [31:0] vel_a_x;
    } contact_t;

    // fields that ride along the divider
    typedef struct packed {
        logic signed [31:0] vel_a_x;
        logic signed [31:0] vel_a_y;
        logic signed [31:0] vel_b_x;
        logic signed [31:0] vel_b_y;
        logic [30:0]        inv_mass_a;
        logic [30:0]        inv_mass_b;
        logic signed [17:0] normal_x;
        logic signed [17:0] normal_y;
        logic               vel_path;
        logic               pos_path;
    } side_t;

    // request into the divider: velocity change and penetration over total inverse mass
    typedef struct packed {
        side_t       side;
        logic [30:0] imp_num;
        logic [30:0] pen_num;
        logic [31:0] total;
    } div_req_t;

    typedef struct packed {
        side_t       side;
        logic [30:0] imp_q;
        logic [30:0] pen_q;
    } div_rsp_t;

    // one result as it leaves on the output stream
    typedef struct packed {
        logic               position_changed;
        logic               velocity_changed;
        logic signed [31:0] shift_b_y;
        logic signed [31:0] shift_b_x;
        logic signed [31:0] shift_a_y;
        logic signed [31:0] shift_a_x;
        logic signed [31:0] new_vel_b_y;
        logic signed [31:0] new_vel_b_x;
        logic signed [31:0] new_vel_a_y;
        logic signed [31:0] new_vel_a_x;
    } result_t;

    function automatic logic signed [31:0] sat32(input logic signed [48:0] x);
        logic signed [31:0] r;
        if (x > SAT_HI)
            r = 32'sh7fffffff;
        else if (x < SAT_LO)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

// ===== design/cir_front.sv =====
// front pipeline: separating velocity, restitution and velocity change
module cir_front
    import cir_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  contact_t    in_data,
    input  logic [16:0] restitution,
    output logic        out_valid,
    output div_req_t    out_data
);

    logic [4:0] valid_reg;

    // stage 1: relative velocity and total inverse mass
    contact_t           c1_reg;
    logic signed [32:0] rvx1_reg, rvy1_reg;
    logic [31:0]        total1_reg;
    // stage 2: products with the normal
    contact_t           c2_reg;
    logic signed [50:0] rvnx2_reg, rvny2_reg;
    logic signed [49:0] acnx2_reg, acny2_reg;
    logic [31:0]        total2_reg;
    // stage 3: dot products
    contact_t           c3_reg;
    logic signed [35:0] sep3_reg;
    logic signed [34:0] acc3_reg;
    logic [31:0]        total3_reg;
    // stage 4: restitution products
    contact_t           c4_reg;
    logic signed [35:0] sep4_reg;
    logic               acc_neg4_reg;
    logic [52:0]        nsep_prod4_reg;
    logic signed [52:0] acc_prod4_reg;
    logic [31:0]        total4_reg;
    // stage 5: request to the divider
    div_req_t           req5_reg;

    logic signed [51:0] sum_v;
    logic signed [50:0] sum_a;
    logic [35:0]        neg_sep;
    logic signed [38:0] nsep_adj;
    logic signed [38:0] nsep_clamped;
    logic signed [39:0] dvel;
    logic [30:0]        dvel_sat;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[3:0], in_valid};
    end

    assign sum_v = $signed({rvnx2_reg[50], rvnx2_reg}) + $signed({rvny2_reg[50], rvny2_reg});
    assign sum_a = $signed({acnx2_reg[49], acnx2_reg}) + $signed({acny2_reg[49], acny2_reg});
    assign neg_sep = 36'(-sep3_reg);

    // new separating speed, floored at zero when the acceleration term applies
    always_comb
    begin
        nsep_adj = $signed({2'b00, nsep_prod4_reg[52:16]});
        if (acc_neg4_reg)
            nsep_adj = nsep_adj + $signed({{2{acc_prod4_reg[52]}}, acc_prod4_reg[52:16]});
        nsep_clamped = (nsep_adj < 0) ? '0 : nsep_adj;
        dvel = $signed({nsep_clamped[38], nsep_clamped})
             - $signed({{4{sep4_reg[35]}}, sep4_reg});
        dvel_sat = (dvel > $signed({9'd0, Q_MAX})) ? Q_MAX : dvel[30:0];
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg     <= in_data;
            rvx1_reg   <= $signed({in_data.vel_a_x[31], in_data.vel_a_x})
                        - $signed({in_data.vel_b_x[31], in_data.vel_b_x});
            rvy1_reg   <= $signed({in_data.vel_a_y[31], in_data.vel_a_y})
                        - $signed({in_data.vel_b_y[31], in_data.vel_b_y});
            total1_reg <= {1'b0, in_data.inv_mass_a} + {1'b0, in_data.inv_mass_b};

            c2_reg     <= c1_reg;
            rvnx2_reg  <= rvx1_reg * c1_reg.normal_x;
            rvny2_reg  <= rvy1_reg * c1_reg.normal_y;
            acnx2_reg  <= c1_reg.rel_acc_x * c1_reg.normal_x;
            acny2_reg  <= c1_reg.rel_acc_y * c1_reg.normal_y;
            total2_reg <= total1_reg;

            c3_reg     <= c2_reg;
            sep3_reg   <= sum_v[51:16];
            acc3_reg   <= sum_a[50:16];
            total3_reg <= total2_reg;

            c4_reg         <= c3_reg;
            sep4_reg       <= sep3_reg;
            acc_neg4_reg   <= acc3_reg[34];
            nsep_prod4_reg <= neg_sep * restitution;
            acc_prod4_reg  <= acc3_reg * $signed({1'b0, restitution});
            total4_reg     <= total3_reg;

            req5_reg.side.vel_a_x    <= c4_reg.vel_a_x;
            req5_reg.side.vel_a_y    <= c4_reg.vel_a_y;
            req5_reg.side.vel_b_x    <= c4_reg.vel_b_x;
            req5_reg.side.vel_b_y    <= c4_reg.vel_b_y;
            req5_reg.side.inv_mass_a <= c4_reg.inv_mass_a;
            req5_reg.side.inv_mass_b <= c4_reg.inv_mass_b;
            req5_reg.side.normal_x   <= c4_reg.normal_x;
            req5_reg.side.normal_y   <= c4_reg.normal_y;
            req5_reg.side.vel_path   <= (sep4_reg <= 0) && (total4_reg != '0);
            req5_reg.side.pos_path   <= (c4_reg.penetration > 0) && (total4_reg != '0);
            req5_reg.imp_num         <= dvel_sat;
            req5_reg.pen_num         <= c4_reg.penetration[30:0];
            req5_reg.total           <= total4_reg;
        end
    end

    assign out_valid = valid_reg[4];
    assign out_data  = req5_reg;

endmodule

// ===== design/cir_div.sv =====
// two-lane pipelined restoring divider, one quotient bit per stage
module cir_div
    import cir_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     in_valid,
    input  div_req_t in_data,
    output logic     out_valid,
    output div_rsp_t out_data
);

    logic [DIV_STEPS:0] valid_reg;
    side_t              side_reg [0:DIV_STEPS];
    logic [31:0]        den_reg  [0:DIV_STEPS];
    logic [31:0]        rem_reg  [0:DIV_STEPS][0:1];
    logic [30:0]        low_reg  [0:DIV_STEPS][0:1];
    logic [30:0]        quo_reg  [0:DIV_STEPS][0:1];
    logic               sat_reg  [0:DIV_STEPS][0:1];
    logic [30:0]        num_in   [0:1];

    assign num_in[0] = in_data.imp_num;
    assign num_in[1] = in_data.pen_num;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[DIV_STEPS-1:0], in_valid};
    end

    // setup stage: saturation test and leading remainder
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_data.side;
            den_reg[0]  <= in_data.total;
        end
    end

    for (genvar l = 0; l < 2; l++)
    begin : g_lane0
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sat_reg[0][l] <= {16'd0, num_in[l]} >= {in_data.total, 15'd0};
                rem_reg[0][l] <= {16'd0, num_in[l][30:15]};
                low_reg[0][l] <= {num_in[l][14:0], 16'd0};
                quo_reg[0][l] <= '0;
            end
        end
    end

    // one compare and subtract per stage
    for (genvar k = 1; k <= DIV_STEPS; k++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k] <= side_reg[k-1];
                den_reg[k]  <= den_reg[k-1];
            end
        end

        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            logic [32:0] trial;
            logic        fits;

            assign trial = {rem_reg[k-1][l], low_reg[k-1][l][30]};
            assign fits  = trial >= {1'b0, den_reg[k-1]};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k][l] <= fits ? 32'(trial - {1'b0, den_reg[k-1]}) : trial[31:0];
                    low_reg[k][l] <= {low_reg[k-1][l][29:0], 1'b0};
                    quo_reg[k][l] <= {quo_reg[k-1][l][29:0], fits};
                    sat_reg[k][l] <= sat_reg[k-1][l];
                end
            end
        end
    end

    assign out_valid      = valid_reg[DIV_STEPS];
    assign out_data.side  = side_reg[DIV_STEPS];
    assign out_data.imp_q = sat_reg[DIV_STEPS][0] ? Q_MAX : quo_reg[DIV_STEPS][0];
    assign out_data.pen_q = sat_reg[DIV_STEPS][1] ? Q_MAX : quo_reg[DIV_STEPS][1];

endmodule

// ===== design/cir_back.sv =====
// back pipeline: impulse and shift along the normal, share by inverse mass
module cir_back
    import cir_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     in_valid,
    input  div_rsp_t in_data,
    output logic     out_valid,
    output result_t  out_data
);

    logic [3:0] valid_reg;

    // stage 1: quotient times normal
    side_t              s1_reg;
    logic signed [49:0] jx1_reg, jy1_reg, mx1_reg, my1_reg;
    // stage 2: saturated impulse and shift vectors
    side_t              s2_reg;
    logic signed [31:0] px2_reg, py2_reg, qx2_reg, qy2_reg;
    // stage 3: share by inverse mass
    side_t              s3_reg;
    logic signed [63:0] pxa3_reg, pya3_reg, pxb3_reg, pyb3_reg;
    logic signed [63:0] qxa3_reg, qya3_reg, qxb3_reg, qyb3_reg;
    // stage 4: result register
    result_t            res_reg;

    logic signed [31:0] ima, imb;
    result_t            res_next;

    assign ima = $signed({1'b0, s2_reg.inv_mass_a});
    assign imb = $signed({1'b0, s2_reg.inv_mass_b});

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[2:0], in_valid};
    end

    // final add, saturation and selection by path
    always_comb
    begin
        res_next.new_vel_a_x = s3_reg.vel_a_x;
        res_next.new_vel_a_y = s3_reg.vel_a_y;
        res_next.new_vel_b_x = s3_reg.vel_b_x;
        res_next.new_vel_b_y = s3_reg.vel_b_y;
        res_next.shift_a_x   = '0;
        res_next.shift_a_y   = '0;
        res_next.shift_b_x   = '0;
        res_next.shift_b_y   = '0;
        res_next.velocity_changed = s3_reg.vel_path;
        res_next.position_changed = s3_reg.pos_path;
        if (s3_reg.vel_path)
        begin
            res_next.new_vel_a_x = sat32(49'(s3_reg.vel_a_x) + 49'($signed(pxa3_reg[63:16])));
            res_next.new_vel_a_y = sat32(49'(s3_reg.vel_a_y) + 49'($signed(pya3_reg[63:16])));
            res_next.new_vel_b_x = sat32(49'(s3_reg.vel_b_x) - 49'($signed(pxb3_reg[63:16])));
            res_next.new_vel_b_y = sat32(49'(s3_reg.vel_b_y) - 49'($signed(pyb3_reg[63:16])));
        end
        if (s3_reg.pos_path)
        begin
            res_next.shift_a_x = sat32(49'($signed(qxa3_reg[63:16])));
            res_next.shift_a_y = sat32(49'($signed(qya3_reg[63:16])));
            res_next.shift_b_x = sat32(-49'($signed(qxb3_reg[63:16])));
            res_next.shift_b_y = sat32(-49'($signed(qyb3_reg[63:16])));
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg  <= in_data.side;
            jx1_reg <= $signed({1'b0, in_data.imp_q}) * in_data.side.normal_x;
            jy1_reg <= $signed({1'b0, in_data.imp_q}) * in_data.side.normal_y;
            mx1_reg <= $signed({1'b0, in_data.pen_q}) * in_data.side.normal_x;
            my1_reg <= $signed({1'b0, in_data.pen_q}) * in_data.side.normal_y;

            s2_reg  <= s1_reg;
            px2_reg <= sat32(49'($signed(jx1_reg[49:16])));
            py2_reg <= sat32(49'($signed(jy1_reg[49:16])));
            qx2_reg <= sat32(49'($signed(mx1_reg[49:16])));
            qy2_reg <= sat32(49'($signed(my1_reg[49:16])));

            s3_reg   <= s2_reg;
            pxa3_reg <= 64'(px2_reg) * 64'(ima);
            pya3_reg <= 64'(py2_reg) * 64'(ima);
            pxb3_reg <= 64'(px2_reg) * 64'(imb);
            pyb3_reg <= 64'(py2_reg) * 64'(imb);
            qxa3_reg <= 64'(qx2_reg) * 64'(ima);
            qya3_reg <= 64'(qy2_reg) * 64'(ima);
            qxb3_reg <= 64'(qx2_reg) * 64'(imb);
            qyb3_reg <= 64'(qy2_reg) * 64'(imb);

            res_reg <= res_next;
        end
    end

    assign out_valid = valid_reg[3];
    assign out_data  = res_reg;

endmodule

// ===== design/contact_impulse_resolver_core.sv =====
// top level of the contact impulse resolver
// Resolves one 2D particle contact per request in signed Q16.16 and returns the
// corrected velocities and position shifts of both bodies. The datapath is a
// 41-stage pipeline (5 front stages, a 32-stage bit-per-stage divider, 4 back
// stages): a new contact is taken every cycle unless the output is stalled.
// The whole pipeline holds while a result waits on m_tready; the last
// stage is the output register. Restitution is written on the cfg channel
// (always ready) and must only change while no contact is in flight.
module contact_impulse_resolver_core
    import cir_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // vel_a_x, vel_a_y, vel_b_x, vel_b_y, rel_acc_x, rel_acc_y, inv_mass_a,
    // inv_mass_b, normal_x, normal_y, penetration, zero pad
    input  logic [327:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y, shift_a_x, shift_a_y,
    // shift_b_x, shift_b_y, velocity_changed, position_changed, zero pad
    output logic [263:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [16:0]  cfg_data
);

    logic [16:0] restitution_reg;
    logic        adv;
    logic        f_valid, d_valid;
    div_req_t    f_data;
    div_rsp_t    d_data;
    result_t     res;

    // restitution register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            restitution_reg <= RESTITUTION_RESET;
        else if (cfg_valid)
            restitution_reg <= cfg_data;
    end

    assign cfg_ready = 1'b1;

    // global pipeline advance
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    cir_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (adv),
        .in_valid    (s_tvalid),
        .in_data     (contact_t'(s_tdata[321:0])),
        .restitution (restitution_reg),
        .out_valid   (f_valid),
        .out_data    (f_data)
    );

    cir_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (f_valid),
        .in_data   (f_data),
        .out_valid (d_valid),
        .out_data  (d_data)
    );

    cir_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (d_valid),
        .in_data   (d_data),
        .out_valid (m_tvalid),
        .out_data  (res)
    );

    assign m_tdata = {6'd0, res};

    // checks
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while pipeline stalled");

    a_no_shift_without_pen: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !res.position_changed |->
            res.shift_a_x == '0 && res.shift_a_y == '0 &&
            res.shift_b_x == '0 && res.shift_b_y == '0)
        else $error("shift present without penetration correction");

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for the contact impulse resolver core
module testbench
    import cir_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 60;
    localparam int PHASE_ITEMS = 250;

    typedef struct {
        contact_t c;
        bit       typed;
        result_t  r;
    } stim_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [327:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [263:0] m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [16:0]  cfg_data;

    // restitution as the predictor sees it
    logic [16:0] restitution_q;
    // expected results, oldest first
    result_t     pending_results[$];
    // typed expectation riding with the request on the bus
    bit          req_typed;
    result_t     req_typed_result;
    bit          quiet;
    int          errors;
    int          cycles;
    int          drain_count;
    stim_row_t   directed[$];

    contact_impulse_resolver_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock, 8 ns period
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic longint clip32(input longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint fshift(input longint x);
        return x >>> FRAC_BITS;
    endfunction

    // resolve one contact the way the block should
    function automatic result_t resolve_contact(input contact_t c, input logic [16:0] rest);
        result_t r;
        longint  vax, vay, vbx, vby, acx, acy, ima, imb, nx, ny, pen, e, tot;
        longint  sep, nsep, acc, d, j, px, py, m, qx, qy;
        vax = c.vel_a_x;
        vay = c.vel_a_y;
        vbx = c.vel_b_x;
        vby = c.vel_b_y;
        acx = c.rel_acc_x;
        acy = c.rel_acc_y;
        ima = longint'({1'b0, c.inv_mass_a});
        imb = longint'({1'b0, c.inv_mass_b});
        nx  = c.normal_x;
        ny  = c.normal_y;
        pen = c.penetration;
        e   = longint'({1'b0, rest});
        tot = ima + imb;
        r = '0;
        r.new_vel_a_x = vax[31:0];
        r.new_vel_a_y = vay[31:0];
        r.new_vel_b_x = vbx[31:0];
        r.new_vel_b_y = vby[31:0];
        sep = fshift((vax - vbx) * nx + (vay - vby) * ny);
        // impulse along the normal for approaching bodies
        if (sep <= 0 && tot != 0)
        begin
            nsep = fshift(-sep * e);
            acc  = fshift(acx * nx + acy * ny);
            if (acc < 0)
            begin
                nsep = nsep + fshift(e * acc);
                if (nsep < 0)
                    nsep = 0;
            end
            d = nsep - sep;
            if (d > 64'sd2147483647)
                d = 64'sd2147483647;
            j = (d <<< FRAC_BITS) / tot;
            if (j > 64'sd2147483647)
                j = 64'sd2147483647;
            px = clip32(fshift(j * nx));
            py = clip32(fshift(j * ny));
            r.new_vel_a_x = 32'(clip32(vax + fshift(px * ima)));
            r.new_vel_a_y = 32'(clip32(vay + fshift(py * ima)));
            r.new_vel_b_x = 32'(clip32(vbx - fshift(px * imb)));
            r.new_vel_b_y = 32'(clip32(vby - fshift(py * imb)));
            r.velocity_changed = 1'b1;
        end
        // penetration shared out by inverse mass
        if (pen > 0 && tot != 0)
        begin
            m = (pen <<< FRAC_BITS) / tot;
            if (m > 64'sd2147483647)
                m = 64'sd2147483647;
            qx = clip32(fshift(m * nx));
            qy = clip32(fshift(m * ny));
            r.shift_a_x = 32'(clip32(fshift(qx * ima)));
            r.shift_a_y = 32'(clip32(fshift(qy * ima)));
            r.shift_b_x = 32'(clip32(-fshift(qx * imb)));
            r.shift_b_y = 32'(clip32(-fshift(qy * imb)));
            r.position_changed = 1'b1;
        end
        return r;
    endfunction

    function automatic contact_t mk(input logic [31:0] vax, vay, vbx, vby, acx, acy,
                                    input logic [30:0] ima, imb,
                                    input logic [17:0] nx, ny,
                                    input logic [31:0] pen);
        contact_t c;
        c.vel_a_x = vax;
        c.vel_a_y = vay;
        c.vel_b_x = vbx;
        c.vel_b_y = vby;
        c.rel_acc_x = acx;
        c.rel_acc_y = acy;
        c.inv_mass_a = ima;
        c.inv_mass_b = imb;
        c.normal_x = nx;
        c.normal_y = ny;
        c.penetration = pen;
        return c;
    endfunction

    function automatic logic [31:0] rand_q32();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
        endcase
    endfunction

    function automatic logic [30:0] rand_inv_mass();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 31'($urandom());
            default: return 31'($urandom_range(0, 4 << 16));
        endcase
    endfunction

    function automatic contact_t rand_contact();
        contact_t c;
        int       k;
        c.vel_a_x = rand_q32();
        c.vel_a_y = rand_q32();
        c.vel_b_x = $urandom_range(0, 7) == 0 ? 32'd0 : rand_q32();
        c.vel_b_y = $urandom_range(0, 7) == 0 ? 32'd0 : rand_q32();
        c.rel_acc_x = rand_q32();
        c.rel_acc_y = rand_q32();
        c.inv_mass_a = rand_inv_mass();
        c.inv_mass_b = rand_inv_mass();
        k = $urandom_range(0, 9);
        // mostly components within plus or minus one, some axis aligned, some raw bits
        if (k == 0)
        begin
            c.normal_x = 18'($urandom());
            c.normal_y = 18'($urandom());
        end
        else if (k < 3)
        begin
            c.normal_x = $urandom_range(0, 1) ? 18'sd65536 : -18'sd65536;
            c.normal_y = '0;
            if ($urandom_range(0, 1))
            begin
                c.normal_y = c.normal_x;
                c.normal_x = '0;
            end
        end
        else
        begin
            c.normal_x = 18'($signed($urandom_range(0, 131072)) - 65536);
            c.normal_y = 18'($signed($urandom_range(0, 131072)) - 65536);
        end
        c.penetration = $urandom_range(0, 4) == 0 ? $urandom()
                      : 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
        return c;
    endfunction

    // stimulus side
    task automatic send_contact(input contact_t c, input bit typed, input result_t r);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11) - 1)
                @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, c};
        req_typed <= typed;
        req_typed_result <= r;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_restitution(input logic [16:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        restitution_q = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // predict every accepted request
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            if (req_typed)
                pending_results.push_back(req_typed_result);
            else
                pending_results.push_back(resolve_contact(contact_t'(s_tdata[321:0]),
                                                          restitution_q));
        end
    end

    // compare every accepted result with the oldest prediction
    always @(posedge clk)
    begin
        result_t got, want;
        bit      bad;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata[257:0]);
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %p", got);
            end
            else
            begin
                want = pending_results.pop_front();
                bad = got.new_vel_a_x !== want.new_vel_a_x
                   || got.new_vel_a_y !== want.new_vel_a_y
                   || got.new_vel_b_x !== want.new_vel_b_x
                   || got.new_vel_b_y !== want.new_vel_b_y
                   || got.shift_a_x !== want.shift_a_x
                   || got.shift_a_y !== want.shift_a_y
                   || got.shift_b_x !== want.shift_b_x
                   || got.shift_b_y !== want.shift_b_y
                   || got.velocity_changed !== want.velocity_changed
                   || got.position_changed !== want.position_changed;
                if (bad)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch\n  exp %p\n  got %p", want, got);
                end
            end
        end
    end

    // receiver stalls in bursts
    initial
    begin
        m_tready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (quiet || $urandom_range(0, 2) != 0)
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 30) - 1)
                    @(negedge clk);
            end
            else
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11) - 1)
                    @(negedge clk);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        logic [16:0] rest_list[7];
        result_t     zero_res, r;
        contact_t    c;
        rest_list = '{17'd0, 17'd65536, 17'd131071, 17'd16384,
                      17'd32768, 17'($urandom_range(0, 65536)), 17'($urandom())};
        errors = 0;
        cycles = 0;
        quiet = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        req_typed = 1'b0;
        req_typed_result = '0;
        restitution_q = RESTITUTION_RESET;
        zero_res = '0;

        // directed rows; typed ones can be read straight off the spec
        directed.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, zero_res});
        c = mk(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 0, 0,
               0, 0, 18'sd65536, 0, 32'h7fffffff);
        r = zero_res;
        r.new_vel_a_x = 32'h7fffffff;
        r.new_vel_a_y = 32'h80000000;
        r.new_vel_b_x = 32'h80000000;
        r.new_vel_b_y = 32'h7fffffff;
        directed.push_back('{c, 1'b1, r});
        // head-on at restitution one half
        c = mk(32'sd65536, 0, 0, 0, 0, 0, 31'd65536, 0, -18'sd65536, 0, 0);
        r = zero_res;
        r.new_vel_a_x = -32'sd32768;
        r.velocity_changed = 1'b1;
        directed.push_back('{c, 1'b1, r});
        // separating contact passes through
        c = mk(-32'sd65536, 0, 0, 0, 0, 0, 31'd65536, 0, -18'sd65536, 0, 0);
        r = zero_res;
        r.new_vel_a_x = -32'sd65536;
        directed.push_back('{c, 1'b1, r});
        // zero separating velocity
        directed.push_back('{mk(5 << 16, 0, 5 << 16, 0, 0, 0, 31'd65536, 31'd65536,
                                18'sd65536, 0, 1), 1'b0, zero_res});
        directed.push_back('{mk(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                                32'h80000000, 32'h80000000, 31'h7fffffff, 31'h7fffffff,
                                -18'sd65536, -18'sd65536, 32'h7fffffff), 1'b0, zero_res});
        directed.push_back('{mk(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                                32'h7fffffff, 32'h7fffffff, 31'd1, 31'h7fffffff,
                                18'sd65536, 18'sd65536, 32'd1), 1'b0, zero_res});
        directed.push_back('{mk(3 << 16, -7 << 16, 0, 0, 1 << 16, 1 << 16, 31'd65536, 31'd1,
                                -18'sd131072, 18'sd131071, 9 << 16), 1'b0, zero_res});
        directed.push_back('{mk(0, -1 << 16, 0, 0, 0, -4 << 16, 31'd65536, 0,
                                0, 18'sd65536, 0), 1'b0, zero_res});
        directed.push_back('{mk(0, -1 << 16, 0, 0, 0, -1 << 10, 31'd65536, 0,
                                0, 18'sd65536, 32'h80000000), 1'b0, zero_res});
        directed.push_back('{mk(-2 << 16, 0, 0, 0, 0, 0, 0, 31'd32768,
                                18'sd65536, 0, 1), 1'b0, zero_res});
        directed.push_back('{mk(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                                32'hffffffff, 32'hffffffff, 31'h7fffffff, 31'h7fffffff,
                                18'h3ffff, 18'h3ffff, 32'hffffffff), 1'b0, zero_res});
        directed.push_back('{mk(32'h55555555, 32'haaaaaaaa, 32'haaaaaaaa, 32'h55555555,
                                32'h55555555, 32'haaaaaaaa, 31'h2aaaaaaa, 31'h55555555,
                                18'h15555, 18'h2aaaa, 32'h55555555), 1'b0, zero_res});

        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
            send_contact(directed[i].c, directed[i].typed, directed[i].r);
        drain();

        // random phases, each at its own restitution
        foreach (rest_list[p])
        begin
            write_restitution(rest_list[p]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 6 && n == PHASE_ITEMS - 200)
                    quiet = 1'b1;
                if (p == 2 && n == PHASE_ITEMS / 2)
                    drain();
                send_contact(rand_contact(), 1'b0, zero_res);
            end
            drain();
        end

        drain_count = 0;
        while (drain_count < TAIL_CYCLES)
        begin
            @(posedge clk);
            drain_count++;
        end
        if (errors == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
